// ----- sv/l2sq_pkg.sv -----
`default_nettype none

package l2sq_pkg;

  // Lane geometry of one input request.
  localparam int LANES   = 8;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 64;
  localparam int COUNT_W = 4;

  // Stream bus widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((2 * WORD_W + COUNT_W + 7) / 8) * 8;
  localparam int SUM_W       = 31;
  localparam int FLOAT_W     = 32;
  localparam int OUT_TDATA_W = ((SUM_W + FLOAT_W + 7) / 8) * 8;

  // Arithmetic widths.
  localparam int SQ_W    = 2 * BYTE_W;
  localparam int CHUNK_W = $clog2(LANES * 255 * 255 + 1);
  localparam int POS_W   = $clog2(SUM_W);
  localparam int MANT_W  = 24;
  localparam int EXP_W   = 8;
  localparam int EXP_BIAS = 127;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Per-request partial sum handed from the front to the back.
  typedef struct packed {
    logic [CHUNK_W-1:0] sum;
    logic               last;
  } chunk_t;

  // Finished vector total handed to the float conversion.
  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             sat;
  } total_t;

endpackage

`default_nettype wire

// ----- sv/l2sq_front.sv -----
`default_nettype none

module l2sq_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [l2sq_pkg::WORD_W-1:0]   left_bytes,
  input  wire logic [l2sq_pkg::WORD_W-1:0]   right_bytes,
  input  wire logic [l2sq_pkg::COUNT_W-1:0]  valid_lanes,
  input  wire logic                          last_chunk,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output l2sq_pkg::chunk_t                   out_chunk
);
  import l2sq_pkg::*;

  logic [BYTE_W-1:0] lane_diff [LANES];
  logic [SQ_W-1:0]   sq_next   [LANES];
  logic [SQ_W-1:0]   sq        [LANES];
  logic              sq_valid;
  logic              sq_last;
  logic              sq_ready;
  logic [CHUNK_W-1:0] lane_total;

  // Absolute difference and square of each lane; lanes past the count read as zero.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (left_bytes[i*BYTE_W +: BYTE_W] >= right_bytes[i*BYTE_W +: BYTE_W]) begin
        lane_diff[i] = left_bytes[i*BYTE_W +: BYTE_W] - right_bytes[i*BYTE_W +: BYTE_W];
      end else begin
        lane_diff[i] = right_bytes[i*BYTE_W +: BYTE_W] - left_bytes[i*BYTE_W +: BYTE_W];
      end
      if (valid_lanes > COUNT_W'(i)) begin
        sq_next[i] = {{BYTE_W{1'b0}}, lane_diff[i]} * {{BYTE_W{1'b0}}, lane_diff[i]};
      end else begin
        sq_next[i] = '0;
      end
    end
  end

  // Each stage loads when it is empty or its contents move on.
  assign sq_ready = !out_valid || out_ready;
  assign in_ready = !sq_valid || sq_ready;

  // Square stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (in_ready) begin
      sq_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      sq      <= sq_next;
      sq_last <= last_chunk;
    end
  end

  // Sum of the lane squares.
  always_comb begin
    lane_total = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_total = lane_total + CHUNK_W'(sq[i]);
    end
  end

  // Sum stage feeding the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sq_ready) begin
      out_valid <= sq_valid;
    end
    if (sq_ready && sq_valid) begin
      out_chunk.sum  <= lane_total;
      out_chunk.last <= sq_last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/l2sq_queue.sv -----
`default_nettype none

module l2sq_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  l2sq_pkg::chunk_t     in_chunk,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output l2sq_pkg::chunk_t     out_chunk
);
  import l2sq_pkg::*;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_QW = $clog2(QUEUE_DEPTH + 1);

  chunk_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [COUNT_QW-1:0] fill;
  logic                push;
  logic                pop;

  assign in_ready  = (fill != COUNT_QW'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_chunk = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_chunk;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/l2sq_accum.sv -----
`default_nettype none

module l2sq_accum (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  l2sq_pkg::chunk_t   in_chunk,
  output logic               out_valid,
  input  wire logic          out_ready,
  output l2sq_pkg::total_t   out_total
);
  import l2sq_pkg::*;

  logic [SUM_W-1:0] running_sum;
  logic             overflow_seen;
  logic [SUM_W:0]   wide_sum;
  logic             clamp;
  logic [SUM_W-1:0] running_sum_next;
  logic             overflow_seen_next;
  logic             take;

  // Add the request's partial sum and clamp at the largest 31-bit value.
  assign wide_sum           = {1'b0, running_sum} + (SUM_W + 1)'(in_chunk.sum);
  assign clamp              = wide_sum > {1'b0, SUM_MAX};
  assign running_sum_next   = clamp ? SUM_MAX : wide_sum[SUM_W-1:0];
  assign overflow_seen_next = overflow_seen || clamp;

  // A closing request waits only for room in the output register.
  assign in_ready = !in_chunk.last || !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take && in_chunk.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (in_chunk.last) begin
          running_sum   <= '0;
          overflow_seen <= 1'b0;
        end else begin
          running_sum   <= running_sum_next;
          overflow_seen <= overflow_seen_next;
        end
      end
    end
  end

  // Finished total of the vector pair.
  always_ff @(posedge clk) begin
    if (take && in_chunk.last) begin
      out_total.total <= running_sum_next;
      out_total.sat   <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/l2sq_fconv.sv -----
`default_nettype none

module l2sq_fconv (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  l2sq_pkg::total_t                         in_total,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [l2sq_pkg::OUT_TDATA_W-1:0]         out_data,
  output logic                                     out_sat
);
  import l2sq_pkg::*;

  // Position of the highest set bit; zero input gives zero.
  function automatic logic [POS_W-1:0] lead_one(input logic [SUM_W-1:0] v);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (v[i]) begin
        pos = POS_W'(i);
      end
    end
    return pos;
  endfunction

  logic             scan_valid;
  logic [SUM_W-1:0] scan_value;
  logic [POS_W-1:0] scan_pos;
  logic             scan_sat;
  logic             out_free;

  logic [SUM_W-1:0]   norm;
  logic [MANT_W-1:0]  mant;
  logic               guard;
  logic               sticky;
  logic               round_up;
  logic [MANT_W:0]    mant_rnd;
  logic               carry;
  logic [EXP_W-1:0]   exponent;
  logic [FLOAT_W-1:0] float_bits;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !scan_valid || out_free;

  // Leading-one search stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (in_ready) begin
      scan_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      scan_value <= in_total.total;
      scan_pos   <= lead_one(in_total.total);
      scan_sat   <= in_total.sat;
    end
  end

  // Normalize, then round to nearest even on the bits below the mantissa.
  always_comb begin
    norm     = scan_value << (POS_W'(SUM_W - 1) - scan_pos);
    mant     = norm[SUM_W-1 -: MANT_W];
    guard    = norm[SUM_W-MANT_W-1];
    sticky   = |norm[SUM_W-MANT_W-2:0];
    round_up = guard && (sticky || mant[0]);
    mant_rnd = {1'b0, mant} + (MANT_W + 1)'(round_up);
    carry    = mant_rnd[MANT_W];
    exponent = EXP_W'(scan_pos) + EXP_W'(EXP_BIAS) + EXP_W'(carry);
    if (scan_value == '0) begin
      float_bits = '0;
    end else if (carry) begin
      float_bits = {1'b0, exponent, {(MANT_W-1){1'b0}}};
    end else begin
      float_bits = {1'b0, exponent, mant_rnd[MANT_W-2:0]};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= scan_valid;
    end
    if (out_free && scan_valid) begin
      out_data <= OUT_TDATA_W'({float_bits, scan_value});
      out_sat  <= scan_sat;
    end
  end

endmodule

`default_nettype wire

// ----- sv/byte_vector_l2_squared_distance.sv -----
`default_nettype none
// Squared Euclidean distance of two byte vectors, eight byte pairs per request.
// Throughput: one input request per cycle unless stalled, set by the eight-lane front end.
// Path to m_axis_tvalid: square, sum, queue, accumulator, leading-one and output registers.
// A four-entry queue between front and accumulator absorbs output stalls.
// Reset (rst, synchronous) clears the running sum, the saturation flag and all valid bits.
// No clearing pass follows reset; the block takes requests in the next cycle.

module byte_vector_l2_squared_distance (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // left_bytes [63:0], right_bytes [127:64], valid_lanes [131:128], zero pad [135:132]
  input  wire logic [l2sq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // last_chunk
  input  wire logic                                 s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // distance_int [30:0], distance_float_bits [62:31], zero pad [63]
  output logic [l2sq_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // saturated
  output logic                                      m_axis_tuser
);
  import l2sq_pkg::*;

  logic   front_valid;
  logic   front_ready;
  chunk_t front_chunk;
  logic   queue_valid;
  logic   queue_ready;
  chunk_t queue_chunk;
  logic   total_valid;
  logic   total_ready;
  total_t total;

  // Front: per-lane squares and their sum.
  l2sq_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .left_bytes  (s_axis_tdata[WORD_W-1:0]),
    .right_bytes (s_axis_tdata[2*WORD_W-1:WORD_W]),
    .valid_lanes (s_axis_tdata[2*WORD_W+COUNT_W-1:2*WORD_W]),
    .last_chunk  (s_axis_tlast),
    .out_valid   (front_valid),
    .out_ready   (front_ready),
    .out_chunk   (front_chunk)
  );

  // Queue between the front and the back.
  l2sq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_chunk  (front_chunk),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_chunk (queue_chunk)
  );

  // Back: saturating accumulation per vector pair.
  l2sq_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (queue_valid),
    .in_ready  (queue_ready),
    .in_chunk  (queue_chunk),
    .out_valid (total_valid),
    .out_ready (total_ready),
    .out_total (total)
  );

  // Back: single-precision conversion and output register.
  l2sq_fconv u_fconv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (total_valid),
    .in_ready  (total_ready),
    .in_total  (total),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_sat   (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // A zero integer result and a zero float result always come together.
  a_zero_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((m_axis_tdata[SUM_W-1:0] == '0) == (m_axis_tdata[SUM_W+FLOAT_W-1:SUM_W] == '0)))
    else $error("integer and float results disagree on zero");

  // A saturated result carries the clamped maximum.
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[SUM_W-1:0] == SUM_MAX))
    else $error("saturation flag without a clamped sum");

  // A closing request taken by the accumulator yields a total in the next cycle.
  a_total_follows: assert property (@(posedge clk) disable iff (rst)
    queue_valid && queue_ready && queue_chunk.last |=> total_valid)
    else $error("closing request produced no total");

  // Nothing is offered on the output right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

// ----- sim/l2sq_checker.sv -----
`timescale 1ns / 1ps

// Watches both stream channels, keeps its own copy of the accumulator,
// predicts each vector distance and compares it with what the block returns.
module l2sq_checker
  import l2sq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen,
  output int                     clamped_seen
);

  localparam int REPORT_LIMIT = 60;

  typedef struct {
    logic [SUM_W-1:0]   sum;
    logic [FLOAT_W-1:0] fbits;
    logic               sat;
  } distance_t;

  distance_t        expected_distances[$];
  logic [SUM_W-1:0] acc_sum;
  logic             acc_clamped;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    clamped_seen = 0;
    acc_sum      = '0;
    acc_clamped  = 1'b0;
  end

  // Integer to IEEE single, round to nearest with ties to even.
  function automatic logic [FLOAT_W-1:0] single_of(input logic [SUM_W-1:0] v);
    int          msb;
    int          sh;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    logic [7:0]  expo;
    if (v == '0) begin
      return '0;
    end
    msb = 0;
    for (int i = 0; i < SUM_W; i++) begin
      if (v[i]) begin
        msb = i;
      end
    end
    if (msb <= 23) begin
      mant = 32'(v) << (23 - msb);
    end else begin
      sh   = msb - 23;
      rem  = 32'(v) & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      mant = 32'(v) >> sh;
      if (rem > half || (rem == half && mant[0])) begin
        mant = mant + 32'd1;
      end
      // Rounding carried into a new binade.
      if (mant == (32'd1 << 24)) begin
        mant = mant >> 1;
        msb  = msb + 1;
      end
    end
    expo = 8'(msb + EXP_BIAS);
    return {1'b0, expo, mant[22:0]};
  endfunction

  function automatic void report_mismatch(input string field, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : watch
    logic [63:0]  total;
    logic [7:0]   a_byte;
    logic [7:0]   b_byte;
    int           count;
    int           diff;
    distance_t    item;
    logic [SUM_W-1:0]   got_sum;
    logic [FLOAT_W-1:0] got_fbits;
    if (!rst) begin
      // Accumulate the squared differences of one accepted request.
      if (s_axis_tvalid && s_axis_tready) begin
        count = int'(s_axis_tdata[2*WORD_W +: COUNT_W]);
        if (count > LANES) begin
          count = LANES;
        end
        total = 64'(acc_sum);
        for (int k = 0; k < count; k++) begin
          a_byte = s_axis_tdata[k*BYTE_W +: BYTE_W];
          b_byte = s_axis_tdata[WORD_W + k*BYTE_W +: BYTE_W];
          diff   = int'(a_byte) - int'(b_byte);
          total  = total + 64'(diff * diff);
        end
        if (total > 64'(SUM_MAX)) begin
          total       = 64'(SUM_MAX);
          acc_clamped = 1'b1;
        end
        acc_sum = total[SUM_W-1:0];
        if (s_axis_tlast) begin
          item.sum   = acc_sum;
          item.fbits = single_of(acc_sum);
          item.sat   = acc_clamped;
          expected_distances.push_back(item);
          acc_sum     = '0;
          acc_clamped = 1'b0;
        end
      end

      // Compare a returned distance with the oldest prediction.
      if (m_axis_tvalid && m_axis_tready) begin
        got_sum   = m_axis_tdata[SUM_W-1:0];
        got_fbits = m_axis_tdata[SUM_W +: FLOAT_W];
        results_seen++;
        if (m_axis_tuser) begin
          clamped_seen++;
        end
        if (expected_distances.size() == 0) begin
          fail_count++;
          $error("unexpected result: distance_int 0x%0h with nothing outstanding", got_sum);
        end else begin
          item = expected_distances.pop_front();
          if (got_sum !== item.sum) begin
            report_mismatch("distance_int", 32'(item.sum), 32'(got_sum));
          end
          if (got_fbits !== item.fbits) begin
            report_mismatch("distance_float_bits", item.fbits, got_fbits);
          end
          if (m_axis_tuser !== item.sat) begin
            report_mismatch("saturated", 32'(item.sat), 32'(m_axis_tuser));
          end
        end
      end
      pending = expected_distances.size();
    end
  end

endmodule

// ----- sim/tb_byte_vector_l2_squared_distance.sv -----
`timescale 1ns / 1ps

// Drives byte vector pairs into the distance block and gives the verdict.
module tb_byte_vector_l2_squared_distance;
  import l2sq_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 850;

  // Byte pattern families for random vectors.
  typedef enum int {
    PAT_RANDOM,
    PAT_EXTREME,
    PAT_NEAR,
    PAT_WIDE
  } pattern_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int fail_count;
  int pending;
  int results_seen;
  int clamped_seen;

  int requests_sent = 0;
  int vectors_sent  = 0;
  int idle_cycles   = 0;
  bit calm          = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_vector_l2_squared_distance i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  l2sq_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .clamped_seen  (clamped_seen)
  );

  // The result side stalls at random except during calm stretches.
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 13);
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offers one request, starting and ending at a falling edge.
  task automatic push_request(input logic [63:0] left, input logic [63:0] right,
                              input int lanes, input bit last);
    while (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, 4'(lanes), right, left};
    s_axis_tlast  <= last;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    requests_sent++;
    if (last) begin
      vectors_sent++;
    end
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Fills eight byte pairs according to a pattern family.
  function automatic void make_pair(input pattern_e pat, output logic [63:0] left,
                                    output logic [63:0] right);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] t;
    for (int k = 0; k < LANES; k++) begin
      case (pat)
        PAT_EXTREME: begin
          a = $urandom_range(1) ? 8'hFF : 8'h00;
          b = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        PAT_NEAR: begin
          a = 8'($urandom_range(255));
          b = a + 8'($urandom_range(6)) - 8'd3;
        end
        PAT_WIDE: begin
          a = 8'($urandom_range(255, 230));
          b = 8'($urandom_range(25));
          if ($urandom_range(1)) begin
            t = a;
            a = b;
            b = t;
          end
        end
        default: begin
          a = 8'($urandom_range(255));
          b = 8'($urandom_range(255));
        end
      endcase
      left[k*8 +: 8]  = a;
      right[k*8 +: 8] = b;
    end
  endfunction

  initial begin : stimulus
    logic [63:0] left;
    logic [63:0] right;
    pattern_e    pat;
    int          len;
    int          lanes;
    int          drain;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes of the bytes and of the lane count.
    push_request('0, '0, LANES, 1'b1);
    push_request('1, '0, LANES, 1'b1);
    push_request('0, '1, LANES, 1'b1);
    push_request(rand_word(), rand_word(), 0, 1'b1);
    push_request('1, '0, 15, 1'b1);
    push_request('0, '1, 9, 1'b1);
    push_request('1, '0, 1, 1'b1);
    push_request(64'h1, 64'h0, 1, 1'b1);
    push_request(64'h00FF_00FF_00FF_00FF, 64'hFF00_FF00_FF00_FF00, LANES, 1'b1);
    push_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, LANES, 1'b1);
    left = rand_word();
    push_request(left, left, LANES, 1'b1);

    // Directed: multi-chunk vectors, with empty chunks opening and closing a vector.
    push_request(rand_word(), rand_word(), LANES, 1'b0);
    push_request(rand_word(), rand_word(), LANES, 1'b0);
    push_request(rand_word(), rand_word(), 3, 1'b1);
    push_request(rand_word(), rand_word(), 0, 1'b0);
    push_request(rand_word(), rand_word(), 7, 1'b1);
    push_request(rand_word(), rand_word(), 12, 1'b0);
    push_request(rand_word(), rand_word(), 0, 1'b1);

    // Random vectors, mostly short; a calm stretch in the middle.
    while (requests_sent < RANDOM_ITEMS) begin
      calm = (requests_sent >= 300 && requests_sent < 450);
      pat  = pattern_e'($urandom_range(3));
      len  = ($urandom_range(9) == 0) ? $urandom_range(70, 20) : $urandom_range(6, 1);
      for (int c = 0; c < len; c++) begin
        make_pair(pat, left, right);
        if ($urandom_range(9) == 0) begin
          lanes = $urandom_range(15);
        end else if (c == len - 1) begin
          lanes = $urandom_range(LANES, 1);
        end else begin
          lanes = LANES;
        end
        push_request(left, right, lanes, c == len - 1);
      end
    end
    calm = 1'b0;

    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (pending != 0) begin
      @(negedge clk);
    end
    for (drain = 0; drain < DRAIN_CYCLES; drain++) begin
      @(negedge clk);
    end

    $display("Sent %0d requests in %0d vectors; checked %0d distances, %0d of them clamped.",
             requests_sent, vectors_sent, results_seen, clamped_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("Mismatches found: %0d", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/l2sq_pkg.sv
sv/l2sq_front.sv
sv/l2sq_queue.sv
sv/l2sq_accum.sv
sv/l2sq_fconv.sv
sv/byte_vector_l2_squared_distance.sv
sim/l2sq_checker.sv
sim/tb_byte_vector_l2_squared_distance.sv
